[rtl/tlbpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tlbpt_pkg;
  localparam int unsigned AddrWidth = 16;
  localparam int unsigned PageWidth = 8;
  localparam int unsigned FrameWidth = 8;
  localparam int unsigned StampWidth = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned FrameCfgWidth = 9;

  localparam logic [0:0] RegMode = 1'b0;
  localparam logic [0:0] RegFrames = 1'b1;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StTlb    = 8'b0000_0010,
    StPt     = 8'b0000_0100,
    StScan   = 8'b0000_1000,
    StScanW  = 8'b0001_0000,
    StOwner  = 8'b0010_0000,
    StUpdate = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic start;
    logic tlb_lookup;
    logic pt_lookup;
    logic scan_step;
    logic owner_read;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tlb_hit;
    logic pt_present;
    logic need_scan;
    logic scan_done;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

[rtl/tlbpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tlbpt_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/tlbpt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = StTlb;
        end
      end
      StTlb: begin
        cmd_o.tlb_lookup = 1'b1;
        state_d = sts_i.tlb_hit ? StUpdate : StPt;
      end
      StPt: begin
        cmd_o.pt_lookup = 1'b1;
        if (sts_i.pt_present) state_d = StUpdate;
        else if (sts_i.need_scan) state_d = StScan;
        else state_d = StUpdate;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StScanW;
      end
      StScanW: begin
        cmd_o.owner_read = 1'b1;
        state_d = StOwner;
      end
      StOwner: state_d = StUpdate;
      StUpdate: begin
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

[rtl/tlbpt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_datapath
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT = 256,
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  [AddrWidth-1:0]    addr_i,
  input  wire                     mode_i,
  input  wire  [FrameCfgWidth-1:0] frames_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  wire                     out_ready_i,
  output logic                    out_valid_o,
  output logic [AddrWidth-1:0]    phys_addr_o,
  output logic                    tlb_hit_o,
  output logic                    page_fault_o,
  output logic                    eviction_o,
  output logic [PageWidth-1:0]    evicted_page_o,
  output logic [CountWidth-1:0]   address_count_o,
  output logic [CountWidth-1:0]   hit_count_o,
  output logic [CountWidth-1:0]   fault_count_o
);
  localparam int unsigned TlbIdxW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned PageIdxW = $clog2(PAGE_COUNT);
  localparam int unsigned FrmIdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FrmCntW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PageRecip = (65536 + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam logic [CountWidth-1:0] CntMax = '1;

  logic [PageWidth-1:0]  tlb_page_q [TLB_ENTRIES];
  logic [FrameWidth-1:0] tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [TlbIdxW-1:0]    fill_q;
  logic [FrameWidth-1:0] page_frame_m [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] present_q;
  logic [PageWidth-1:0]  owner_m [MAX_FRAMES];
  logic [StampWidth-1:0] load_m [MAX_FRAMES];
  logic [StampWidth-1:0] acc_m [MAX_FRAMES];
  logic [FrmCntW-1:0]    free_q;
  logic [StampWidth-1:0] time_q;
  logic [CountWidth-1:0] addr_tot_q, hit_tot_q, flt_tot_q;

  logic [OFFSET_WIDTH-1:0] off_q;
  logic [PageIdxW-1:0]     page_q;
  logic [FrmIdxW-1:0]      frame_q;
  logic                    hit_q, fault_q, evict_q;
  logic [PageWidth-1:0]    evicted_q;
  logic [FrameWidth-1:0]   pf_rd_q;
  logic [StampWidth-1:0]   st_rd_q, best_st_q;
  logic [FrmIdxW-1:0]      best_q;
  logic [FrmCntW-1:0]      scan_q, rd_idx_q;
  logic                    rd_vld_q, first_q;
  logic [PageWidth-1:0]    owner_rd_q;

  logic [FrmCntW-1:0] limit;
  always_comb begin
    if (frames_i == '0) limit = FrmCntW'(1);
    else if (frames_i > FrameCfgWidth'(MAX_FRAMES)) limit = FrmCntW'(MAX_FRAMES);
    else limit = FrmCntW'(frames_i);
  end

  logic tlb_match;
  logic [FrameWidth-1:0] tlb_mframe;
  always_comb begin
    tlb_match = 1'b0;
    tlb_mframe = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_page_q[i] == PageWidth'(page_q)) begin
        tlb_match = 1'b1;
        tlb_mframe = tlb_frame_q[i];
      end
    end
  end

  assign sts_o.tlb_hit = tlb_match;
  assign sts_o.pt_present = present_q[page_q];
  assign sts_o.need_scan = (free_q >= limit);
  assign sts_o.scan_done = rd_vld_q && (rd_idx_q == limit - FrmCntW'(1));
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

  logic [PageWidth-1:0] page_full;
  assign page_full = PageWidth'(addr_i >> OFFSET_WIDTH);

  // page modulo by reciprocal multiply, exact for 8-bit pages
  logic [23:0]          page_prod;
  logic [PageWidth-1:0] page_quo;
  logic [16:0]          page_back;
  logic [PageIdxW-1:0]  page_mod;
  assign page_prod = {16'd0, page_full} * 24'(PageRecip);
  assign page_quo = page_prod[23:16];
  assign page_back = {9'd0, page_quo} * 17'(PAGE_COUNT);
  assign page_mod = PageIdxW'(page_full - page_back[PageWidth-1:0]);

  always_ff @(posedge clk_i) begin
    pf_rd_q <= page_frame_m[page_q];
    st_rd_q <= mode_i ? acc_m[FrmIdxW'(scan_q)] : load_m[FrmIdxW'(scan_q)];
    owner_rd_q <= owner_m[best_q];
    if (cmd_i.update) begin
      if (fault_q) begin
        page_frame_m[page_q] <= FrameWidth'(frame_q);
        owner_m[frame_q] <= PageWidth'(page_q);
        load_m[frame_q] <= time_q;
        acc_m[frame_q] <= time_q;
      end else if (mode_i) begin
        acc_m[frame_q] <= time_q;
      end
    end
    if (cmd_i.update && !hit_q) begin
      tlb_page_q[fill_q] <= PageWidth'(page_q);
      tlb_frame_q[fill_q] <= FrameWidth'(frame_q);
    end
    if (cmd_i.start) begin
      off_q <= addr_i[OFFSET_WIDTH-1:0];
      page_q <= page_mod;
      hit_q <= 1'b0;
      fault_q <= 1'b0;
      evict_q <= 1'b0;
      evicted_q <= '0;
      scan_q <= '0;
      rd_vld_q <= 1'b0;
      first_q <= 1'b1;
    end
    if (cmd_i.tlb_lookup && tlb_match) begin
      hit_q <= 1'b1;
      frame_q <= FrmIdxW'(tlb_mframe);
    end
    if (cmd_i.pt_lookup) begin
      if (present_q[page_q]) begin
        frame_q <= FrmIdxW'(pf_rd_q);
      end else begin
        fault_q <= 1'b1;
        if (free_q < limit) frame_q <= FrmIdxW'(free_q);
        else evict_q <= 1'b1;
      end
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + FrmCntW'(1);
      rd_idx_q <= scan_q;
      rd_vld_q <= (scan_q < limit);
      if (rd_vld_q) begin
        first_q <= 1'b0;
        if (first_q || st_rd_q < best_st_q) begin
          best_st_q <= st_rd_q;
          best_q <= FrmIdxW'(rd_idx_q);
        end
      end
    end
    if (cmd_i.owner_read) frame_q <= best_q;
    if (evict_q && !cmd_i.start && !cmd_i.update) evicted_q <= PageWidth'(owner_rd_q);
  end

  // pf_rd_q and owner_rd_q are registered reads of their addresses
  logic [PageIdxW-1:0] old_page;
  assign old_page = PageIdxW'(evicted_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
      fill_q <= '0;
      present_q <= '0;
      free_q <= '0;
      time_q <= '0;
      addr_tot_q <= '0;
      hit_tot_q <= '0;
      flt_tot_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.start) begin
        time_q <= time_q + StampWidth'(1);
        if (addr_tot_q != CntMax) addr_tot_q <= addr_tot_q + CountWidth'(1);
      end
      if (cmd_i.update) begin
        logic [TLB_ENTRIES-1:0] v;
        logic [PAGE_COUNT-1:0] p;
        v = tlb_valid_q;
        p = present_q;
        if (hit_q && hit_tot_q != CntMax) hit_tot_q <= hit_tot_q + CountWidth'(1);
        if (fault_q) begin
          if (flt_tot_q != CntMax) flt_tot_q <= flt_tot_q + CountWidth'(1);
          if (evict_q) begin
            p[old_page] = 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
              if (tlb_page_q[i] == PageWidth'(old_page)) v[i] = 1'b0;
          end else begin
            free_q <= free_q + FrmCntW'(1);
          end
          p[page_q] = 1'b1;
        end
        if (!hit_q) begin
          v[fill_q] = 1'b1;
          fill_q <= (fill_q == TlbIdxW'(TLB_ENTRIES - 1)) ? '0 : fill_q + TlbIdxW'(1);
        end
        tlb_valid_q <= v;
        present_q <= p;
      end
      if (cmd_i.emit) out_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      phys_addr_o <= AddrWidth'({FrameWidth'(frame_q), off_q});
      tlb_hit_o <= hit_q;
      page_fault_o <= fault_q;
      eviction_o <= evict_q;
      evicted_page_o <= evict_q ? PageWidth'(old_page) : '0;
      address_count_o <= addr_tot_q;
      hit_count_o <= hit_tot_q;
      fault_count_o <= flt_tot_q;
    end
  end
endmodule
`default_nettype wire

[rtl/tlb_page_table_translator.sv]
`timescale 1ns / 1ps
`default_nettype none
// translates one logical address per item through a tlb and a page table;
// a tlb hit goes straight to the update, a page-table hit or free-frame
// fault first reads the page table, and a fault with all frames in use
// also runs a one-stamp-per-cycle victim scan over the stamp memory
module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT = 256,
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire  [2:2] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  tlbpt_if.sink      in_if,
  tlbpt_if.source    out_if
);
  logic mode_q;
  logic [FrameCfgWidth-1:0] frames_q;
  cmd_t cmd;
  sts_t sts;
  logic [AddrWidth-1:0] pa;
  logic hit, flt, ev;
  logic [PageWidth-1:0] evp;
  logic [CountWidth-1:0] ac, hc, fc;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      RegMode: prdata = {31'b0, mode_q};
      default: prdata = {23'b0, frames_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      frames_q <= FrameCfgWidth'(256);
    end else if (psel && penable && pwrite) begin
      if (paddr == RegMode) mode_q <= pwdata[0];
      else frames_q <= pwdata[FrameCfgWidth-1:0];
    end
  end

  tlbpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
    .MAX_FRAMES(MAX_FRAMES), .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni,
    .addr_i(in_if.data), .mode_i(mode_q), .frames_i(frames_q),
    .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .phys_addr_o(pa), .tlb_hit_o(hit), .page_fault_o(flt),
    .eviction_o(ev), .evicted_page_o(evp),
    .address_count_o(ac), .hit_count_o(hc), .fault_count_o(fc)
  );

  assign out_if.data = {pa, hit, flt, ev, evp, ac, hc, fc};
endmodule
`default_nettype wire

[rtl/tlbpt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [122:0] out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("beat dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[104] |-> out_data[105]) else $error("eviction without fault");
  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data[106] && out_data[105])) else $error("hit and fault");
endmodule

bind tlb_page_table_translator tlbpt_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
